### rtl/rwf_pkg.sv
// Shared types, constants and codes for the RGB 3x3 window filter.
// No dependencies; used by every module of the block but rwf_ram.
package rwf_pkg;

    // Frame geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W     = 12;
    localparam int CNT_W     = DIM_W + 1;
    localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);
    localparam logic [DIM_W-1:0] W_MAX   =
        DIM_W'((MAX_WIDTH > (2 ** DIM_W) - 1) ? (2 ** DIM_W) - 1 : MAX_WIDTH);

    // Configuration port
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;

    // Datapath widths
    localparam int RAW_W      = 13;
    localparam int OFF_W      = 9;
    localparam int BLUR_SHIFT = 15;
    localparam int BLUR_RECIP = 3641;   // ceil(2^15 / 9), exact floor for sums up to 2295

    typedef logic [7:0]             chan_t;
    typedef chan_t [8:0]            chan_win_t;   // index row*3 + column
    typedef logic signed [RAW_W-1:0] raw_t;
    typedef logic signed [OFF_W-1:0] off_t;

    localparam chan_t CHAN_MAX = 8'hFF;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    // One line-store entry: pixel two rows up and pixel one row up
    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_pair_t;

    typedef enum logic [2:0] {
        MODE_COPY    = 3'd0,
        MODE_NEG     = 3'd1,
        MODE_BLUR    = 3'd2,
        MODE_SHARPEN = 3'd3,
        MODE_SOBEL   = 3'd4,
        MODE_EMBOSS  = 3'd5,
        MODE_MAX     = 3'd6
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE      = 3'd0,
        CFG_WIDTH     = 3'd1,
        CFG_HEIGHT    = 3'd2,
        CFG_RED_OFF   = 3'd3,
        CFG_GREEN_OFF = 3'd4,
        CFG_BLUE_OFF  = 3'd5,
        CFG_KEEP      = 3'd6
    } cfg_idx_t;

    // Control handed to each channel filter
    typedef struct packed {
        mode_t mode;
        logic  ring;
    } filt_ctl_t;

endpackage

### rtl/rwf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/rwf_chan_filter.sv
// Per-channel 3x3 kernel evaluation: copy, negative, blur, sharpen, Sobel,
// emboss and maximum. Combinational; depends on rwf_pkg.
module rwf_chan_filter (
    input  rwf_pkg::chan_win_t win,
    input  rwf_pkg::filt_ctl_t ctl,
    output rwf_pkg::raw_t      raw
);
    import rwf_pkg::*;

    chan_t                       centre;
    logic [RAW_W-1:0]            row0_sum;
    logic [RAW_W-1:0]            row1_sum;
    logic [RAW_W-1:0]            row2_sum;
    logic [RAW_W-1:0]            box_sum;
    logic [RAW_W+BLUR_SHIFT-1:0] blur_prod;
    logic [RAW_W-1:0]            blur_val;
    logic [RAW_W-1:0]            sharp_val;
    logic [RAW_W-1:0]            sobel_val;
    logic [RAW_W-1:0]            emboss_val;
    chan_t                       max_01;
    chan_t                       max_23;
    chan_t                       max_45;
    chan_t                       max_67;
    chan_t                       max_03;
    chan_t                       max_47;
    chan_t                       max_07;
    chan_t                       max_all;
    logic [RAW_W-1:0]            res;

    function automatic logic [RAW_W-1:0] ext(chan_t v);
        return RAW_W'(v);
    endfunction

    function automatic chan_t max2(chan_t a, chan_t b);
        return (a > b) ? a : b;
    endfunction

    assign centre = win[4];

    // Box sum as a small tree
    assign row0_sum = ext(win[0]) + ext(win[1]) + ext(win[2]);
    assign row1_sum = ext(win[3]) + ext(win[4]) + ext(win[5]);
    assign row2_sum = ext(win[6]) + ext(win[7]) + ext(win[8]);
    assign box_sum  = row0_sum + row1_sum + row2_sum;

    // Divide by nine: reciprocal multiply, floor
    assign blur_prod = (RAW_W+BLUR_SHIFT)'(box_sum) * (RAW_W+BLUR_SHIFT)'(BLUR_RECIP);
    assign blur_val  = RAW_W'(blur_prod >> BLUR_SHIFT);

    // 10*centre - box sum, two's complement in RAW_W bits
    assign sharp_val = (ext(centre) << 3) + (ext(centre) << 1) - box_sum;

    assign sobel_val = ext(win[0]) + (ext(win[1]) << 1) + ext(win[2])
                     - ext(win[6]) - (ext(win[7]) << 1) - ext(win[8]);

    assign emboss_val = ext(win[1]) + ext(win[2]) + ext(win[5]) + ext(win[7]) + ext(win[8])
                      - ext(win[0]) - ext(win[3]) - ext(win[4]) - ext(win[6]);

    // Maximum tree
    assign max_01  = max2(win[0], win[1]);
    assign max_23  = max2(win[2], win[3]);
    assign max_45  = max2(win[4], win[5]);
    assign max_67  = max2(win[6], win[7]);
    assign max_03  = max2(max_01, max_23);
    assign max_47  = max2(max_45, max_67);
    assign max_07  = max2(max_03, max_47);
    assign max_all = max2(max_07, win[8]);

    // Mode select; negative ignores the border, other kernels pass it through
    always_comb
    begin
        if (ctl.mode == MODE_NEG)
        begin
            res = ext(CHAN_MAX) - ext(centre);
        end
        else if (ctl.ring)
        begin
            res = ext(centre);
        end
        else
        begin
            unique case (ctl.mode)
                MODE_BLUR:    res = blur_val;
                MODE_SHARPEN: res = sharp_val;
                MODE_SOBEL:   res = sobel_val;
                MODE_EMBOSS:  res = emboss_val;
                MODE_MAX:     res = ext(max_all);
                default:      res = ext(centre);
            endcase
        end
    end

    assign raw = raw_t'(res);

endmodule

### rtl/rgb_window_filter_3x3_top.sv
// Top level of the RGB 3x3 window filter: config registers, frame counters,
// line store, window registers and the output stage. Uses rwf_pkg, rwf_ram,
// rwf_chan_filter.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  config  | cfg_write            | cfg_index, cfg_data
//  input   | in_valid / in_ready  | pix_red, pix_green, pix_blue, flush
//  output  | out_valid / out_ready| out_red, out_green, out_blue, frame_last
//
// One request per clock sustained unless the output stalls; a result leaves
// via line-store read, window shift, kernel and offset/saturate registers.
// The result for a pixel appears with the request image_width+1 positions
// later; flush requests supply those positions at frame end.
// A stalled output fills the four stages in turn before in_ready drops.
// Reset restores register defaults and zeroes counters and window; the line
// store needs no clearing.
module rgb_window_filter_3x3_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [rwf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rwf_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rwf_pkg::chan_t              pix_red,
    input  rwf_pkg::chan_t              pix_green,
    input  rwf_pkg::chan_t              pix_blue,
    input  logic                        flush,
    output logic                        out_valid,
    input  logic                        out_ready,
    output rwf_pkg::chan_t              out_red,
    output rwf_pkg::chan_t              out_green,
    output rwf_pkg::chan_t              out_blue,
    output logic                        frame_last
);
    import rwf_pkg::*;

    // Configuration registers
    mode_t            mode_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    off_t             red_off_reg;
    off_t             green_off_reg;
    off_t             blue_off_reg;
    logic [2:0]       keep_reg;

    // Frame position
    logic [COL_W-1:0] col_cnt_reg;
    logic [COL_W-1:0] col_cnt_next;
    logic [CNT_W-1:0] row_cnt_reg;
    logic [CNT_W-1:0] row_cnt_next;

    // Request decode
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [CNT_W-1:0] col_ext;
    logic [CNT_W-1:0] col_inc;
    logic [CNT_W-1:0] w_ext;
    logic [CNT_W-1:0] h_ext;
    logic             drain;
    logic             take;
    logic             emit;
    logic             last;
    logic             wrap;
    logic             ring;
    pixel_t           pix_in;

    // Stage enables
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic s1_adv;

    // Stage 1: line-store read in flight
    logic             s1_valid_reg;
    pixel_t           s1_pix_reg;
    logic [COL_W-1:0] s1_idx_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic             s1_ring_reg;
    logic             byp_valid_reg;
    line_pair_t       byp_data_reg;
    line_pair_t       ram_q;
    line_pair_t       line_eff;
    line_pair_t       line_wr;

    // Stage 2: window holds the item
    pixel_t    win_reg [9];
    logic      s2_valid_reg;
    logic      s2_last_reg;
    logic      s2_ring_reg;
    filt_ctl_t filt_ctl;
    chan_win_t win_red;
    chan_win_t win_green;
    chan_win_t win_blue;
    raw_t      raw_red;
    raw_t      raw_green;
    raw_t      raw_blue;

    // Stage 3: raw kernel values
    logic s3_valid_reg;
    logic s3_last_reg;
    raw_t s3_red_reg;
    raw_t s3_green_reg;
    raw_t s3_blue_reg;

    // Output register
    logic  out_valid_reg;
    logic  out_last_reg;
    chan_t out_red_reg;
    chan_t out_green_reg;
    chan_t out_blue_reg;

    // Offset, keep mask and saturation
    function automatic chan_t finish_chan(raw_t raw, off_t off, logic keep);
        logic signed [RAW_W:0] sum;
        chan_t                 res;
        sum = (RAW_W+1)'(raw) + (RAW_W+1)'(off);
        if (!keep || sum < 0)
        begin
            res = '0;
        end
        else if (sum > (RAW_W+1)'(signed'({1'b0, CHAN_MAX})))
        begin
            res = CHAN_MAX;
        end
        else
        begin
            res = sum[7:0];
        end
        return res;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_COPY;
            width_reg     <= DIM_W'(640);
            height_reg    <= DIM_W'(480);
            red_off_reg   <= '0;
            green_off_reg <= '0;
            blue_off_reg  <= '0;
            keep_reg      <= 3'b111;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MODE:      mode_reg      <= mode_t'(cfg_data[2:0]);
                CFG_WIDTH:     width_reg     <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:    height_reg    <= cfg_data[DIM_W-1:0];
                CFG_RED_OFF:   red_off_reg   <= off_t'(cfg_data[OFF_W-1:0]);
                CFG_GREEN_OFF: green_off_reg <= off_t'(cfg_data[OFF_W-1:0]);
                CFG_BLUE_OFF:  blue_off_reg  <= off_t'(cfg_data[OFF_W-1:0]);
                CFG_KEEP:      keep_reg      <= cfg_data[2:0];
                default:       ;
            endcase
        end
    end

    // Clamped frame size
    always_comb
    begin
        if (width_reg < DIM_MIN)
        begin
            w_eff = DIM_MIN;
        end
        else if (width_reg > W_MAX)
        begin
            w_eff = W_MAX;
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg < DIM_MIN) ? DIM_MIN : height_reg;
    end

    // Request decode against the current frame position
    assign col_ext = CNT_W'(col_cnt_reg);
    assign col_inc = col_ext + CNT_W'(1);
    assign w_ext   = CNT_W'(w_eff);
    assign h_ext   = CNT_W'(h_eff);
    assign drain   = row_cnt_reg >= h_ext;
    assign take    = in_valid && in_ready && !(flush && !drain);
    assign emit    = (row_cnt_reg >= CNT_W'(2))
                  || (row_cnt_reg == CNT_W'(1) && col_cnt_reg != '0);
    assign last    = row_cnt_reg >= h_ext + CNT_W'(1);
    assign wrap    = col_inc >= w_ext;
    assign ring    = last || (!wrap && col_ext <= CNT_W'(1))
                  || row_cnt_reg <= CNT_W'(1) || row_cnt_reg >= h_ext;
    assign pix_in  = drain ? '0 : pixel_t'{red: pix_red, green: pix_green, blue: pix_blue};

    // Next frame position
    always_comb
    begin
        priority if (last)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (wrap)
        begin
            col_cnt_next = '0;
            row_cnt_next = row_cnt_reg + CNT_W'(1);
        end
        else
        begin
            col_cnt_next = col_inc[COL_W-1:0];
            row_cnt_next = row_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (take)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Stage enables: each stage moves when the one after it is empty or moving
    assign en4      = !out_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign s1_adv   = s1_valid_reg && en2;

    // Line store: read on accept, written back when the item leaves stage 1
    assign line_eff = byp_valid_reg ? byp_data_reg : ram_q;
    assign line_wr  = line_pair_t'{upper: line_eff.middle, middle: s1_pix_reg};

    rwf_ram #(
        .WIDTH ($bits(line_pair_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_idx_reg),
        .wr_data (line_wr),
        .rd_en   (take),
        .rd_addr (col_cnt_reg),
        .rd_data (ram_q)
    );

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= take;
            end
            // same-address write in this cycle: forward the written entry
            if (take)
            begin
                byp_valid_reg <= s1_adv && (s1_idx_reg == col_cnt_reg);
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pix_reg   <= pix_in;
            s1_idx_reg   <= col_cnt_reg;
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
            s1_ring_reg  <= ring;
            byp_data_reg <= line_wr;
        end
    end

    // Stage 2: window shift and item control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            end
            if (s1_adv)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]     <= win_reg[r*3 + 1];
                    win_reg[r*3 + 1] <= win_reg[r*3 + 2];
                end
                win_reg[2] <= line_eff.upper;
                win_reg[5] <= line_eff.middle;
                win_reg[8] <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_last_reg <= s1_last_reg;
            s2_ring_reg <= s1_ring_reg;
        end
    end

    // Channel windows and kernels
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            win_red[i]   = win_reg[i].red;
            win_green[i] = win_reg[i].green;
            win_blue[i]  = win_reg[i].blue;
        end
    end

    assign filt_ctl = filt_ctl_t'{mode: mode_reg, ring: s2_ring_reg};

    rwf_chan_filter u_filt_red (
        .win (win_red),
        .ctl (filt_ctl),
        .raw (raw_red)
    );

    rwf_chan_filter u_filt_green (
        .win (win_green),
        .ctl (filt_ctl),
        .raw (raw_green)
    );

    rwf_chan_filter u_filt_blue (
        .win (win_blue),
        .ctl (filt_ctl),
        .raw (raw_blue)
    );

    // Stage 3: raw values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en3)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && en3)
        begin
            s3_last_reg  <= s2_last_reg;
            s3_red_reg   <= raw_red;
            s3_green_reg <= raw_green;
            s3_blue_reg  <= raw_blue;
        end
    end

    // Output register: offset, mask, saturate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en4)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && en4)
        begin
            out_last_reg  <= s3_last_reg;
            out_red_reg   <= finish_chan(s3_red_reg, red_off_reg, keep_reg[0]);
            out_green_reg <= finish_chan(s3_green_reg, green_off_reg, keep_reg[1]);
            out_blue_reg  <= finish_chan(s3_blue_reg, blue_off_reg, keep_reg[2]);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = out_red_reg;
    assign out_green  = out_green_reg;
    assign out_blue   = out_blue_reg;
    assign frame_last = out_last_reg;

endmodule

### rtl/rwf_checker.sv
// Port-level checks for the RGB 3x3 window filter, bound to the top level.
// Depends on rwf_pkg and rgb_window_filter_3x3_top.
module rwf_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input rwf_pkg::chan_t out_red,
    input rwf_pkg::chan_t out_green,
    input rwf_pkg::chan_t out_blue,
    input logic           frame_last
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
            && $stable(out_blue) && $stable(frame_last))
        else $error("stalled result changed");

    // Whenever the output register can move, the pipeline is ready for a request
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("in_ready low while output side is free");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid && in_ready)
        else $error("pipeline not empty in reset");

endmodule

bind rgb_window_filter_3x3_top rwf_checker u_rwf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .frame_last (frame_last)
);
